// File: rtl/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern scanner
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int PAT_BYTES       = 16;
    localparam int OFS_OUT_W       = 32;
    localparam int CNT_W           = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int LEN_REG_W       = 5;

    localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2,
        REG_WILDCARD = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                 found;
        logic [OFS_OUT_W-1:0] offset;
        logic                 done;
        logic [CNT_W-1:0]     total;
    } scan_res_t;

endpackage

`default_nettype wire

// File: rtl/wildcard_byte_pattern_scanner.sv
// top level of the wildcard byte pattern scanner
// path: a byte is held in the input register, and its result beat is registered in the output buffer
// throughput: one byte per cycle while the output buffer has room; the window compare and position update
//   are combinational between the input register and the result slots
// reset: aresetn clears the window, positions, match counter and the
//   configuration registers (length 1, wildcard on); no clearing pass
`default_nettype none

module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // byte stream in
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // [7:0] data_byte
    input  wire logic                            s_tlast,
    // result stream out
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [63:0]                          m_tdata,  // [31:0] match_offset, [63:32] match_total
    output logic                                 m_tuser,  // [0] match_found
    output logic                                 m_tlast,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_data_reg;
    logic                   in_last_reg;
    logic                   fire;
    logic                   room;
    logic                   res_push;
    scan_res_t              res;
    scan_res_t              m_res;
    logic [LEN_W-1:0]       eff_len;
    logic [7:0]             pat_aligned [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pat_care;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    wbps_cfg_regs #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .eff_len     (eff_len),
        .pat_aligned (pat_aligned),
        .pat_care    (pat_care)
    );

    wbps_match_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS),
        .LEN_W       (LEN_W)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .data_byte      (in_data_reg),
        .last_in_region (in_last_reg),
        .eff_len        (eff_len),
        .pat_aligned    (pat_aligned),
        .pat_care       (pat_care),
        .res_push       (res_push),
        .res            (res)
    );

    wbps_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_push),
        .push_res (res),
        .room     (room),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {m_res.total, m_res.offset};
    assign m_tuser = m_res.found;
    assign m_tlast = m_res.done;

endmodule

`default_nettype wire

// File: rtl/wbps_cfg_regs.sv
// configuration registers and the length-aligned compare pattern
`default_nettype none

module wbps_cfg_regs #(
    parameter int MAX_PATTERN = 16,
    parameter int LEN_W       = 5
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [LEN_W-1:0]                     eff_len,
    output logic [7:0]                           pat_aligned [MAX_PATTERN],
    output logic [MAX_PATTERN-1:0]               pat_care
);
    import wbps_pkg::*;

    logic [CFG_DATA_W-1:0] pat_low_reg, pat_low_next;
    logic [CFG_DATA_W-1:0] pat_high_reg, pat_high_next;
    logic [LEN_REG_W-1:0]  len_reg, len_next;
    logic                  wild_reg, wild_next;
    logic [7:0]            pat_byte [PAT_BYTES];

    assign cfg_ready = 1'b1;

    always_comb begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        len_next      = len_reg;
        wild_next     = wild_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PAT_LOW:  pat_low_next  = cfg_data;
                REG_PAT_HIGH: pat_high_next = cfg_data;
                REG_PAT_LEN:  len_next      = cfg_data[LEN_REG_W-1:0];
                REG_WILDCARD: wild_next     = cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= LEN_REG_W'(1);
            wild_reg     <= 1'b1;
        end else begin
            pat_low_reg  <= pat_low_next;
            pat_high_reg <= pat_high_next;
            len_reg      <= len_next;
            wild_reg     <= wild_next;
        end
    end

    always_comb begin
        for (int b = 0; b < PAT_BYTES / 2; b++) begin
            pat_byte[b]                 = pat_low_reg[8*b +: 8];
            pat_byte[b + PAT_BYTES / 2] = pat_high_reg[8*b +: 8];
        end
    end

    // zero length acts as one, long lengths clamp to the window depth
    always_comb begin
        int l;
        l = int'(len_reg);
        if (l == 0) begin
            l = 1;
        end
        if (l > MAX_PATTERN) begin
            l = MAX_PATTERN;
        end
        eff_len = LEN_W'(l);
    end

    // window slot k (newest first) lines up with pattern byte len-1-k
    always_comb begin
        int         j;
        logic [7:0] p;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            j = int'(eff_len) - 1 - k;
            p = 8'h00;
            if (j >= 0 && j < PAT_BYTES) begin
                p = pat_byte[j[3:0]];
            end
            if (k < int'(eff_len)) begin
                pat_aligned[k] = p;
                pat_care[k]    = !(wild_reg && p == WILDCARD_BYTE);
            end else begin
                pat_aligned[k] = 8'h00;
                pat_care[k]    = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/wbps_match_core.sv
// byte window, masked parallel compare and per-region position state
`default_nettype none

module wbps_match_core #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32,
    parameter int LEN_W       = 5
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   fire,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   last_in_region,
    input  wire logic [LEN_W-1:0]       eff_len,
    input  wire logic [7:0]             pat_aligned [MAX_PATTERN],
    input  wire logic [MAX_PATTERN-1:0] pat_care,
    output logic                        res_push,
    output wbps_pkg::scan_res_t         res
);
    import wbps_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    logic [7:0]             win_reg [MAX_PATTERN];
    logic [7:0]             win_next [MAX_PATTERN];
    logic [7:0]             win_shift [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] resume_reg, resume_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic                   saturated;
    logic [OFFSET_BITS:0]   pos_plus1;
    logic [OFFSET_BITS:0]   start;
    logic                   all_match;
    logic                   found;
    logic [CNT_W-1:0]       cnt_inc;

    always_comb begin
        win_shift[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            win_shift[k] = win_reg[k-1];
        end
    end

    always_comb begin
        all_match = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (pat_care[k] && pat_aligned[k] != win_shift[k]) begin
                all_match = 1'b0;
            end
        end
    end

    assign saturated = (pos_reg == POS_MAX);
    assign pos_plus1 = {1'b0, pos_reg} + (OFFSET_BITS+1)'(1);
    assign start     = pos_plus1 - (OFFSET_BITS+1)'(eff_len);

    // the whole match must sit inside the region and after the last match
    assign found = !saturated && (pos_plus1 >= (OFFSET_BITS+1)'(eff_len))
                 && (start >= {1'b0, resume_reg}) && all_match;

    assign cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + CNT_W'(1);

    assign res_push     = fire && (found || last_in_region);
    assign res.found    = found;
    assign res.offset   = found ? OFS_OUT_W'(start) : '0;
    assign res.done     = last_in_region;
    assign res.total    = found ? cnt_inc : cnt_reg;

    always_comb begin
        win_next    = win_reg;
        pos_next    = pos_reg;
        resume_next = resume_reg;
        cnt_next    = cnt_reg;
        if (fire) begin
            if (last_in_region) begin
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    win_next[k] = 8'h00;
                end
                pos_next    = '0;
                resume_next = '0;
                cnt_next    = '0;
            end else begin
                win_next = win_shift;
                if (!saturated) begin
                    pos_next = pos_plus1[OFFSET_BITS-1:0];
                end
                if (found) begin
                    resume_next = pos_plus1[OFFSET_BITS-1:0];
                    cnt_next    = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_reg[k] <= 8'h00;
            end
            pos_reg    <= '0;
            resume_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            win_reg    <= win_next;
            pos_reg    <= pos_next;
            resume_reg <= resume_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/wbps_out_buf.sv
// two-slot result register with skid slot for the master side
`default_nettype none

module wbps_out_buf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire wbps_pkg::scan_res_t push_res,
    output logic                     room,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output wbps_pkg::scan_res_t      m_res
);
    import wbps_pkg::*;

    logic      head_valid_reg, head_valid_next;
    logic      tail_valid_reg, tail_valid_next;
    scan_res_t head_reg, head_next;
    scan_res_t tail_reg, tail_next;
    logic      pop;

    assign pop     = head_valid_reg && m_ready;
    assign room    = !tail_valid_reg;
    assign m_valid = head_valid_reg;
    assign m_res   = head_reg;

    always_comb begin
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        if (pop) begin
            if (tail_valid_reg) begin
                head_next       = tail_reg;
                tail_valid_next = 1'b0;
            end else begin
                head_valid_next = push;
                head_next       = push_res;
            end
        end else if (push) begin
            if (!head_valid_reg) begin
                head_valid_next = 1'b1;
                head_next       = push_res;
            end else begin
                tail_valid_next = 1'b1;
                tail_next       = push_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire
